FILE: sv/mips_subset_instruction_executor_defines.svh
// Assertion macros for the MIPS subset executor checker.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define MSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mse check failed");

// next-cycle implication
`define MSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mse check failed");

`endif

FILE: sv/mse_pkg.sv
// Shared types, codes and constants of the MIPS subset executor.
package mse_pkg;

  typedef logic [31:0] word_t;

  localparam int MEM_BYTES = 65536;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int ROWS      = MEM_BYTES / 4;
  localparam int ROW_W     = ADDR_W - 2;

  localparam word_t PC_RESET  = 32'h0000_1000;
  localparam word_t HALT_WORD = 32'hffff_ffff;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [1:0] ACT_EXEC     = 2'd0;
  localparam logic [1:0] ACT_PRELOAD  = 2'd1;
  localparam logic [1:0] ACT_RESTART  = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam logic [2:0] ST_EXEC    = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_PRELOAD = 3'd3;
  localparam logic [2:0] ST_RESTART = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_JR  = 6'h08;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a;

  function automatic word_t rf_preset(input logic [4:0] idx);
    word_t v;
    case (idx)
      5'd16:   v = 32'h0000_0010;
      5'd17:   v = 32'h0000_1000;
      5'd18:   v = 32'h0000_0020;
      5'd19:   v = 32'h0000_0003;
      5'd20:   v = 32'hbada_cafe;
      5'd21:   v = 32'hcdcd_cdcd;
      5'd22:   v = 32'hffff_ffff;
      5'd23:   v = 32'h0000_0007;
      5'd29:   v = 32'h0000_8000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/mse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/mips_subset_instruction_executor.sv
// MIPS32 subset executor: one instruction, preload or restart per input beat.
//
// Input channel (in_valid/in_stall) carries action, instr_word, preload_addr
// and preload_data; output channel (out_valid/out_stall) returns one result
// beat per input beat, in order. start_pc is written through cfg_wr_en and
// cfg_wr_data, by the user only while idle; the block does not enforce this.
// Pipeline: operand stage (register file read), memory stage (data memory
// read for lw), output register. While out_stall is low one beat per cycle
// is sustained, lw included, since register results are forwarded from the
// memory stage and the last write. Data memory is four byte-wide banks so
// an unaligned word touches each bank once. After reset a clearing pass
// zeroes the memory, one row of all banks per cycle; in_stall stays high
// meanwhile and the register file reads its preset values until each entry
// is written. When out_stall is high the output register holds and the
// pipeline fills, then in_stall rises.
module mips_subset_instruction_executor (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  mse_pkg::word_t cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    action,
  input  mse_pkg::word_t instr_word,
  input  logic [15:0]   preload_addr,
  input  mse_pkg::word_t preload_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    status,
  output mse_pkg::word_t pc_after,
  output logic          reg_write_en,
  output logic [4:0]    reg_dest,
  output mse_pkg::word_t reg_result,
  output logic          mem_write_en,
  output logic [15:0]   store_addr,
  output mse_pkg::word_t store_value
);
  import mse_pkg::*;

  word_t start_pc, pc;
  logic clearing;
  logic [ROW_W-1:0] clr_row;
  logic [31:0] rf_valid;

  // operand stage
  logic s1_valid, s1_rs_valid, s1_rt_valid;
  logic [1:0] s1_action;
  word_t s1_instr, s1_pdata;
  logic [15:0] s1_paddr;

  // memory stage
  logic s2_valid, s2_wen, s2_load, s2_men;
  logic [2:0] s2_status;
  logic [4:0] s2_dst;
  logic [1:0] s2_off;
  logic [15:0] s2_saddr;
  word_t s2_pc, s2_val, s2_sval, s2_res, ldw;

  // last register write
  logic wb_en;
  logic [4:0] wb_dst;
  word_t wb_val;

  logic out_adv, s2_adv, s2_free, s1_adv, s1_free, in_acc;

  assign out_adv = !out_valid || !out_stall;
  assign s2_adv  = s2_valid && out_adv;
  assign s2_free = !s2_valid || out_adv;
  assign s1_adv  = s1_valid && s2_free;
  assign s1_free = !s1_valid || s2_free;
  assign in_stall = clearing || !s1_free;
  assign in_acc   = in_valid && !in_stall;

  // register file: two copies for two read ports
  word_t rf_a, rf_b, a, b, rf_wdata;
  logic rf_we;
  assign rf_we    = s2_adv && s2_wen;
  assign rf_wdata = s2_res;

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(s2_dst), .wdata(rf_wdata),
    .re(in_acc), .raddr(instr_word[25:21]), .rdata(rf_a)
  );
  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(s2_dst), .wdata(rf_wdata),
    .re(in_acc), .raddr(instr_word[20:16]), .rdata(rf_b)
  );

  logic [5:0] op, funct;
  logic [4:0] rs, rt, rd, sh;
  assign op    = s1_instr[31:26];
  assign rs    = s1_instr[25:21];
  assign rt    = s1_instr[20:16];
  assign rd    = s1_instr[15:11];
  assign sh    = s1_instr[10:6];
  assign funct = s1_instr[5:0];

  always_comb begin
    if (s2_valid && s2_wen && s2_dst == rs) begin
      a = s2_res;
    end else if (wb_en && wb_dst == rs) begin
      a = wb_val;
    end else if (s1_rs_valid) begin
      a = rf_a;
    end else begin
      a = rf_preset(rs);
    end
  end

  always_comb begin
    if (s2_valid && s2_wen && s2_dst == rt) begin
      b = s2_res;
    end else if (wb_en && wb_dst == rt) begin
      b = wb_val;
    end else if (s1_rt_valid) begin
      b = rf_b;
    end else begin
      b = rf_preset(rt);
    end
  end

  // execute
  word_t pc4, simm, zimm, br_tgt, j_tgt, x_pc, x_val, eff_addr, mdata, maddr32;
  logic [2:0] x_status;
  logic x_wr, x_load, x_men, x_pre, x_wen;
  logic [4:0] x_dst;
  logic [ADDR_W-1:0] maddr;

  always_comb begin
    pc4    = pc + 32'd4;
    simm   = {{16{s1_instr[15]}}, s1_instr[15:0]};
    zimm   = {16'h0000, s1_instr[15:0]};
    br_tgt = pc4 + {simm[29:0], 2'b00};
    j_tgt  = {pc4[31:28], s1_instr[25:0], 2'b00};
    x_status = ST_EXEC;
    x_pc   = pc;
    x_wr   = 1'b0;
    x_dst  = rt;
    x_val  = '0;
    x_load = 1'b0;
    x_men  = 1'b0;
    x_pre  = 1'b0;
    case (s1_action)
      ACT_PRELOAD: begin
        x_status = ST_PRELOAD;
        x_pre = 1'b1;
      end
      ACT_RESTART: begin
        x_status = ST_RESTART;
        x_pc = start_pc;
      end
      ACT_EXEC: begin
        x_pc = pc4;
        if (s1_instr == HALT_WORD) begin
          x_status = ST_HALT;
        end else if (op == OP_RTYPE) begin
          x_dst = rd;
          x_wr  = 1'b1;
          case (funct)
            FN_ADD: x_val = a + b;
            FN_SUB: x_val = a - b;
            FN_AND: x_val = a & b;
            FN_OR:  x_val = a | b;
            FN_NOR: x_val = ~(a | b);
            FN_SLL: x_val = b << sh;
            FN_SRL: x_val = b >> sh;
            FN_SRA: x_val = word_t'($signed(b) >>> sh);
            FN_SLT: x_val = {31'd0, $signed(a) < $signed(b)};
            FN_JR: begin
              x_wr = 1'b0;
              x_pc = a;
            end
            default: begin
              x_wr = 1'b0;
              x_status = ST_UNKNOWN;
            end
          endcase
        end else begin
          case (op)
            OP_ADDI: begin x_wr = 1'b1; x_val = a + simm; end
            OP_ANDI: begin x_wr = 1'b1; x_val = a & zimm; end
            OP_ORI:  begin x_wr = 1'b1; x_val = a | zimm; end
            OP_SLTI: begin x_wr = 1'b1; x_val = {31'd0, $signed(a) < $signed(simm)}; end
            OP_LW:   begin x_wr = 1'b1; x_load = 1'b1; end
            OP_SW:   x_men = 1'b1;
            OP_BEQ:  if (a == b) x_pc = br_tgt;
            OP_BNE:  if (a != b) x_pc = br_tgt;
            OP_J:    x_pc = j_tgt;
            OP_JAL: begin
              x_wr  = 1'b1;
              x_dst = REG_RA;
              x_val = pc4;
              x_pc  = j_tgt;
            end
            default: x_status = ST_UNKNOWN;
          endcase
        end
      end
      default: x_status = ST_UNKNOWN;
    endcase
    x_wen    = x_wr && (x_dst != 5'd0);
    eff_addr = x_pre ? {16'h0000, s1_paddr} : a + simm;
    maddr    = eff_addr[ADDR_W-1:0];
    maddr32  = 32'(maddr);
    mdata    = x_pre ? s1_pdata : b;
  end

  // data memory banks
  logic [1:0] off;
  logic [ROW_W-1:0] row;
  logic bank_we;
  logic [ROW_W-1:0] bank_addr [4];
  logic [7:0] bank_wdata [4];
  logic [7:0] bank_rd [4];
  logic [1:0] bsel;

  assign off = maddr[1:0];
  assign row = maddr[ADDR_W-1:2];
  assign bank_we = clearing || (s1_adv && (x_pre || x_men));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bsel = 2'(k) - off;
      bank_addr[k]  = row + ROW_W'(2'(k) < off);
      bank_wdata[k] = mdata[{~bsel, 3'b000} +: 8];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk(clk), .we(bank_we),
      .waddr(clearing ? clr_row : bank_addr[k]),
      .wdata(clearing ? 8'h00 : bank_wdata[k]),
      .re(s1_adv), .raddr(bank_addr[k]), .rdata(bank_rd[k])
    );
  end

  logic [1:0] lsel;
  always_comb begin
    ldw = '0;
    for (int i = 0; i < 4; i++) begin
      lsel = 2'(i) + s2_off;
      ldw[{~2'(i), 3'b000} +: 8] = bank_rd[lsel];
    end
  end

  assign s2_res = s2_load ? ldw : s2_val;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc  <= PC_RESET;
      pc        <= PC_RESET;
      clearing  <= 1'b1;
      clr_row   <= '0;
      rf_valid  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      wb_en     <= 1'b0;
    end else begin
      if (cfg_wr_en) start_pc <= cfg_wr_data;
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
        if (clr_row == ROW_W'(ROWS - 1)) clearing <= 1'b0;
      end
      if (s1_adv) pc <= x_pc;
      if (rf_we) begin
        rf_valid[s2_dst] <= 1'b1;
        wb_en <= 1'b1;
      end
      if (s1_free) s1_valid <= in_acc;
      if (s2_free) s2_valid <= s1_adv;
      if (out_adv) out_valid <= s2_adv;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action   <= action;
      s1_instr    <= instr_word;
      s1_paddr    <= preload_addr;
      s1_pdata    <= preload_data;
      s1_rs_valid <= rf_valid[instr_word[25:21]];
      s1_rt_valid <= rf_valid[instr_word[20:16]];
    end
    if (s1_adv) begin
      s2_status <= x_status;
      s2_pc     <= x_pc;
      s2_wen    <= x_wen;
      s2_dst    <= x_wen ? x_dst : 5'd0;
      s2_val    <= x_wen ? x_val : '0;
      s2_load   <= x_load && x_wen;
      s2_off    <= off;
      s2_men    <= x_men;
      s2_saddr  <= x_men ? maddr32[15:0] : 16'h0000;
      s2_sval   <= x_men ? b : '0;
    end
    if (rf_we) begin
      wb_dst <= s2_dst;
      wb_val <= s2_res;
    end
    if (s2_adv) begin
      status       <= s2_status;
      pc_after     <= s2_pc;
      reg_write_en <= s2_wen;
      reg_dest     <= s2_dst;
      reg_result   <= s2_res;
      mem_write_en <= s2_men;
      store_addr   <= s2_saddr;
      store_value  <= s2_sval;
    end
  end

endmodule

FILE: sv/mse_chk.sv
// Port-level checks of the MIPS subset executor, bound to the top level.
`include "mips_subset_instruction_executor_defines.svh"

module mse_chk (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input logic [2:0]    status,
  input mse_pkg::word_t pc_after,
  input logic          reg_write_en,
  input logic [4:0]    reg_dest,
  input logic          mem_write_en
);
  import mse_pkg::*;

  `MSE_ASSERT_NOW(a_status_code, out_valid,
    status == ST_EXEC || status == ST_HALT || status == ST_UNKNOWN ||
    status == ST_PRELOAD || status == ST_RESTART)
  `MSE_ASSERT_NOW(a_no_r0_write, out_valid && reg_write_en, reg_dest != 5'd0)
  `MSE_ASSERT_NOW(a_quiet_status, out_valid && status != ST_EXEC,
    !reg_write_en && !mem_write_en)
  `MSE_ASSERT_NOW(a_one_write, out_valid, !(reg_write_en && mem_write_en))
  `MSE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(pc_after))

endmodule

bind mips_subset_instruction_executor mse_chk u_mse_chk (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the MIPS subset executor: random and directed beats.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mse_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    word_t       instr_word;
    logic [15:0] preload_addr;
    word_t       preload_data;
  } beat_in_t;

  typedef struct packed {
    logic [2:0]  status;
    word_t       pc_after;
    logic        reg_write_en;
    logic [4:0]  reg_dest;
    word_t       reg_result;
    logic        mem_write_en;
    logic [15:0] store_addr;
    word_t       store_value;
  } beat_out_t;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  word_t cfg_wr_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] action = '0;
  word_t instr_word = '0, preload_data = '0;
  logic [15:0] preload_addr = '0;
  logic in_stall, out_valid;
  logic [2:0] status;
  word_t pc_after, reg_result, store_value;
  logic reg_write_en, mem_write_en;
  logic [4:0] reg_dest;
  logic [15:0] store_addr;

  mips_subset_instruction_executor dut (.*);

  initial forever #5 clk = ~clk;

  // model state
  word_t    m_regs [32];
  word_t    m_pc, m_start_pc;
  logic [7:0] m_mem [MEM_BYTES];

  beat_in_t  pending_beats[$];
  beat_out_t expected_results[$];
  int errors = 0;
  int hold_cycles = 0;
  bit hold_go = 0;
  bit hold_seen = 0;

  function automatic word_t mem_word(word_t a);
    word_t v = '0;
    for (int i = 0; i < 4; i++) v = {v[23:0], m_mem[16'(a + i)]};
    return v;
  endfunction

  function automatic void mem_put(word_t a, word_t v);
    for (int i = 0; i < 4; i++) m_mem[16'(a + i)] = v[31 - 8*i -: 8];
  endfunction

  function automatic beat_out_t execute_beat(beat_in_t b);
    beat_out_t r = '0;
    word_t w = b.instr_word, pc, ra, rb, simm, val;
    logic [5:0] op;
    logic [4:0] dst;
    bit wr = 0;
    op = w[31:26];
    if (b.action == ACT_PRELOAD) begin
      mem_put({16'h0, b.preload_addr}, b.preload_data);
      r.status = ST_PRELOAD;
    end else if (b.action == ACT_RESTART) begin
      m_pc = m_start_pc;
      r.status = ST_RESTART;
    end else if (b.action != ACT_EXEC) begin
      r.status = ST_UNKNOWN;
    end else begin
      m_pc += 4;
      pc = m_pc;
      ra = m_regs[w[25:21]];
      rb = m_regs[w[20:16]];
      simm = {{16{w[15]}}, w[15:0]};
      val = '0;
      r.status = ST_EXEC;
      if (w == HALT_WORD) r.status = ST_HALT;
      else if (op == OP_RTYPE) begin
        wr = 1;
        dst = w[15:11];
        case (w[5:0])
          FN_ADD: val = ra + rb;
          FN_SUB: val = ra - rb;
          FN_AND: val = ra & rb;
          FN_OR:  val = ra | rb;
          FN_NOR: val = ~(ra | rb);
          FN_SLL: val = rb << w[10:6];
          FN_SRL: val = rb >> w[10:6];
          FN_SRA: val = $signed(rb) >>> w[10:6];
          FN_SLT: val = word_t'($signed(ra) < $signed(rb));
          FN_JR:  begin wr = 0; pc = ra; end
          default: begin wr = 0; r.status = ST_UNKNOWN; end
        endcase
      end else begin
        dst = w[20:16];
        case (op)
          OP_ADDI: begin wr = 1; val = ra + simm; end
          OP_ANDI: begin wr = 1; val = ra & {16'h0, w[15:0]}; end
          OP_ORI:  begin wr = 1; val = ra | {16'h0, w[15:0]}; end
          OP_SLTI: begin wr = 1; val = word_t'($signed(ra) < $signed(simm)); end
          OP_LW:   begin wr = 1; val = mem_word(ra + simm); end
          OP_SW: begin
            r.mem_write_en = 1;
            r.store_addr = 16'(ra + simm);
            r.store_value = rb;
            mem_put(ra + simm, rb);
          end
          OP_BEQ: if (ra == rb) pc += simm << 2;
          OP_BNE: if (ra != rb) pc += simm << 2;
          OP_J:   pc = {pc[31:28], w[25:0], 2'b00};
          OP_JAL: begin
            wr = 1; dst = REG_RA; val = pc; pc = {pc[31:28], w[25:0], 2'b00};
          end
          default: r.status = ST_UNKNOWN;
        endcase
      end
      if (wr && dst != 0) begin
        m_regs[dst] = val;
        r.reg_write_en = 1;
        r.reg_dest = dst;
        r.reg_result = val;
      end
      m_pc = pc;
    end
    r.pc_after = m_pc;
    return r;
  endfunction

  function automatic int short_gap();
    int p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_beat(
          '{action, instr_word, preload_addr, preload_data}));
        void'(pending_beats.pop_front());
        in_gap = short_gap();
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0 || pending_beats.size() == 0) begin
          if (in_gap > 0) in_gap = in_gap - 1;
          in_valid <= 0;
        end else begin
          in_valid <= 1;
          action <= pending_beats[0].action;
          instr_word <= pending_beats[0].instr_word;
          preload_addr <= pending_beats[0].preload_addr;
          preload_data <= pending_beats[0].preload_data;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1;
      hold_cycles <= 60;
    end else if (hold_cycles > 0)
      hold_cycles <= hold_cycles - 1;
  end

  // hold pending beat removal in sync: pop after accept, so front is always next
  // monitor
  always @(posedge clk) begin
    beat_out_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, status); errors++; end
          if (pc_after !== exp_r.pc_after) begin
            $error("pc_after exp %h got %h", exp_r.pc_after, pc_after); errors++; end
          if (reg_write_en !== exp_r.reg_write_en) begin
            $error("reg_write_en exp %b got %b", exp_r.reg_write_en, reg_write_en);
            errors++; end
          if (reg_dest !== exp_r.reg_dest) begin
            $error("reg_dest exp %0d got %0d", exp_r.reg_dest, reg_dest); errors++; end
          if (reg_result !== exp_r.reg_result) begin
            $error("reg_result exp %h got %h", exp_r.reg_result, reg_result); errors++; end
          if (mem_write_en !== exp_r.mem_write_en) begin
            $error("mem_write_en exp %b got %b", exp_r.mem_write_en, mem_write_en);
            errors++; end
          if (store_addr !== exp_r.store_addr) begin
            $error("store_addr exp %h got %h", exp_r.store_addr, store_addr); errors++; end
          if (store_value !== exp_r.store_value) begin
            $error("store_value exp %h got %h", exp_r.store_value, store_value);
            errors++; end
        end
      end
      if (hold_cycles > 0)
        out_stall <= 1;
      else
        out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
    end
  end

  function automatic word_t rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic word_t itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  task automatic queue_exec(word_t w);
    pending_beats.push_back('{ACT_EXEC, w, 16'($urandom), $urandom});
  endtask

  task automatic queue_preload(logic [15:0] a, word_t d);
    pending_beats.push_back('{ACT_PRELOAD, $urandom, a, d});
  endtask

  task automatic queue_restart();
    pending_beats.push_back('{ACT_RESTART, $urandom, 16'($urandom), $urandom});
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start_pc(word_t v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    m_start_pc = v;
    @(posedge clk);
  endtask

  function automatic word_t random_instr();
    logic [5:0] ops [11] = '{OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_LW, OP_SW,
                            OP_BEQ, OP_BNE, OP_J, OP_JAL, OP_RTYPE};
    logic [5:0] fns [10] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_NOR, FN_SLL,
                            FN_SRL, FN_SRA, FN_SLT, FN_JR};
    word_t w = $urandom;
    int p = $urandom_range(0, 99);
    if (p < 3) return HALT_WORD;
    if (p < 8) return w;
    w[31:26] = ops[$urandom_range(0, 10)];
    if (w[31:26] == OP_RTYPE) w[5:0] = fns[$urandom_range(0, 9)];
    if ($urandom_range(0, 1)) w[25:21] = 5'($urandom_range(16, 23));
    if (w[31:26] == OP_LW || w[31:26] == OP_SW) w[25:21] = 5'd29;
    return w;
  endfunction

  initial begin
    word_t starts [4] = '{32'h0, 32'hffff_fffc, 32'h0000_1000, 32'h8000_0000};
    for (int i = 0; i < 32; i++) m_regs[i] = rf_preset(5'(i));
    m_pc = PC_RESET;
    m_start_pc = PC_RESET;
    for (int i = 0; i < MEM_BYTES; i++) m_mem[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed
    queue_exec(rtype(5'd20, 5'd21, 5'd1, 5'd0, FN_ADD));
    queue_exec(rtype(5'd16, 5'd22, 5'd2, 5'd0, FN_SUB));
    queue_exec(rtype(5'd20, 5'd21, 5'd3, 5'd9, FN_AND));
    queue_exec(rtype(5'd20, 5'd21, 5'd4, 5'd0, FN_OR));
    queue_exec(rtype(5'd20, 5'd0, 5'd5, 5'd0, FN_NOR));
    queue_exec(rtype(5'd0, 5'd22, 5'd6, 5'd31, FN_SLL));
    queue_exec(rtype(5'd0, 5'd22, 5'd7, 5'd31, FN_SRL));
    queue_exec(rtype(5'd0, 5'd20, 5'd8, 5'd0, FN_SRA));
    queue_exec(rtype(5'd0, 5'd21, 5'd9, 5'd31, FN_SRA));
    queue_exec(rtype(5'd22, 5'd16, 5'd10, 5'd0, FN_SLT));
    queue_exec(rtype(5'd20, 5'd21, 5'd0, 5'd0, FN_ADD));
    queue_exec(itype(OP_ADDI, 5'd16, 5'd11, 16'h8000));
    queue_exec(itype(OP_ANDI, 5'd22, 5'd12, 16'hffff));
    queue_exec(itype(OP_ORI, 5'd0, 5'd13, 16'h8001));
    queue_exec(itype(OP_SLTI, 5'd16, 5'd14, 16'hffff));
    queue_preload(16'hfffe, 32'h1234_5678);
    queue_exec(itype(OP_LW, 5'd0, 5'd15, 16'hfffe));
    queue_exec(itype(OP_SW, 5'd22, 5'd21, 16'h0000));
    queue_exec(itype(OP_BEQ, 5'd0, 5'd0, 16'h8000));
    queue_exec(itype(OP_BNE, 5'd16, 5'd0, 16'h7fff));
    queue_exec({OP_J, 26'h3ff_ffff});
    queue_exec({OP_JAL, 26'h000_0000});
    queue_exec(rtype(5'd17, 5'd0, 5'd0, 5'd0, FN_JR));
    queue_exec(HALT_WORD);
    queue_exec({6'h3f, 26'h0});
    queue_exec(rtype(5'd0, 5'd0, 5'd1, 5'd0, 6'h3f));
    pending_beats.push_back('{ACT_RESERVED, $urandom, 16'($urandom), $urandom});
    queue_restart();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_start_pc(starts[ph]);
      queue_restart();
      for (int i = 0; i < 325; i++) begin
        int p = $urandom_range(0, 99);
        if (p < 80) queue_exec(random_instr());
        else if (p < 92) queue_preload(16'($urandom), $urandom);
        else if (p < 97) queue_restart();
        else pending_beats.push_back('{ACT_RESERVED, $urandom, 16'($urandom), $urandom});
      end
      if (ph == 1) begin
        repeat (20) @(posedge clk);
        hold_go = 1;
      end
      wait_drained();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/mse_pkg.sv
sv/mse_ram.sv
sv/mips_subset_instruction_executor.sv
sv/mse_chk.sv
tb/sv/tb.sv
